>>> rtl/nepc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nepc_pkg
// Shared types, field widths and codes for the nibble error pattern checker.
// ---------------------------------------------------------------------------
package nepc_pkg;

   // default sizes handed to the top level
   localparam int COLUMNS_DEFAULT          = 256;
   localparam int MAX_MESSAGE_BITS_DEFAULT = 64;

   // transaction field widths
   localparam int OP_W       = 2;
   localparam int SLOT_W     = 8;
   localparam int DATA_W     = 64;
   localparam int FIRST_W    = 6;
   localparam int COUNT_W    = 7;
   localparam int MSG_BITS_W = 7;

   // operation codes
   localparam logic [OP_W-1:0] OP_LOAD_COLUMN = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_CHUNK  = 2'd1;
   localparam logic [OP_W-1:0] OP_CHECK       = 2'd2;

   // message width after reset
   localparam logic [MSG_BITS_W-1:0] MESSAGE_BITS_RESET = 7'd64;

   // forbidden nibble patterns: 0111, 1011 and everything above 1100
   localparam logic [3:0] NIB_BAD_LOW  = 4'h7;
   localparam logic [3:0] NIB_BAD_MID  = 4'hb;
   localparam logic [3:0] NIB_TOP_GOOD = 4'hc;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic issue;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic more;
      logic pending;
   } dp_status_type;

   function automatic logic nibble_bad(input logic [3:0] nib);
      return (nib == NIB_BAD_LOW) || (nib == NIB_BAD_MID) || (nib > NIB_TOP_GOOD);
   endfunction

endpackage

>>> rtl/nepc_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nepc_ctrl
// Sequencer: accepts a transaction, steps the group walk of a check and
// raises the result strobe for one cycle.
// ---------------------------------------------------------------------------
module nepc_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [nepc_pkg::OP_W-1:0]     req_operation,
   output logic                          busy,
   output logic                          rsp_strobe,
   output nepc_pkg::dp_cmd_type          cmd,
   input  nepc_pkg::dp_status_type       status
);

   nepc_pkg::state_type state_ff, state_in;
   logic                accept;

   // handshake
   assign busy   = (state_ff != nepc_pkg::ST_IDLE);
   assign accept = start && (state_ff == nepc_pkg::ST_IDLE);

   // commands to the datapath
   assign cmd.accept = accept;
   assign cmd.issue  = (state_ff == nepc_pkg::ST_RUN) && status.more;

   assign rsp_strobe = (state_ff == nepc_pkg::ST_DONE);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         nepc_pkg::ST_IDLE: begin
            if (start) begin
               if (req_operation == nepc_pkg::OP_CHECK) begin
                  state_in = nepc_pkg::ST_RUN;
               end else begin
                  state_in = nepc_pkg::ST_DONE;
               end
            end
         end
         // last group read is evaluated on the edge that leaves this state
         nepc_pkg::ST_RUN: begin
            if (!status.more) begin
               state_in = nepc_pkg::ST_DONE;
            end
         end
         nepc_pkg::ST_DONE: begin
            state_in = nepc_pkg::ST_IDLE;
         end
         default: begin
            state_in = nepc_pkg::ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nepc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/nepc_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nepc_datapath
// Column banks, received word store, group counter and the nibble check.
// ---------------------------------------------------------------------------
module nepc_datapath #(
   parameter int COLUMNS          = nepc_pkg::COLUMNS_DEFAULT,
   parameter int MAX_MESSAGE_BITS = nepc_pkg::MAX_MESSAGE_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  nepc_pkg::dp_cmd_type              cmd,
   output nepc_pkg::dp_status_type           status,
   input  logic [nepc_pkg::OP_W-1:0]         req_operation,
   input  logic [nepc_pkg::SLOT_W-1:0]       req_slot_index,
   input  logic [nepc_pkg::DATA_W-1:0]       req_data_word,
   input  logic [nepc_pkg::FIRST_W-1:0]      req_first_group,
   input  logic [nepc_pkg::COUNT_W-1:0]      req_group_count,
   input  logic                              csr_write_enable,
   input  logic [nepc_pkg::MSG_BITS_W-1:0]   csr_write_data,
   output logic                              candidate_valid,
   output logic                              was_check
);

   localparam int W           = MAX_MESSAGE_BITS;
   localparam int GROUP_LIMIT = COLUMNS / 4;
   localparam int BANK_DEPTH  = (COLUMNS + 3) / 4;
   localparam int BANK_AW     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int CHUNK_DEPTH = (COLUMNS + 63) / 64;
   localparam int CHUNK_AW    = (CHUNK_DEPTH > 1) ? $clog2(CHUNK_DEPTH) : 1;
   localparam int END_MAX     = (1 << nepc_pkg::FIRST_W) - 1 + (1 << nepc_pkg::COUNT_W) - 1;
   localparam int GROUP_W     =
      $clog2(((GROUP_LIMIT > END_MAX) ? GROUP_LIMIT : END_MAX) + 1);

   logic [nepc_pkg::MSG_BITS_W-1:0] msg_bits_ff;
   logic [nepc_pkg::MSG_BITS_W-1:0] bits_used;
   logic [W-1:0]                    use_mask;

   logic [W-1:0]         cand_ff;
   logic [GROUP_W-1:0]   group_ff, group_in;
   logic [GROUP_W-1:0]   end_ff, end_in;
   logic [GROUP_W-1:0]   range_end;
   logic                 pend_ff;
   logic                 ok_ff;
   logic                 check_ff;

   logic                 col_we;
   logic [BANK_AW-1:0]   col_waddr;
   logic [BANK_AW-1:0]   col_raddr;
   logic                 chunk_we;
   logic [CHUNK_AW-1:0]  chunk_waddr;
   logic [CHUNK_AW-1:0]  chunk_raddr;
   logic [GROUP_W-1:0]   group_shift;

   logic [W-1:0]         col_rd_ff [4];
   logic [63:0]          chunk_mem [CHUNK_DEPTH];
   logic [63:0]          chunk_rd_ff;
   logic [3:0]           sub_ff;
   logic [63:0]          chunk_aligned;
   logic [3:0]           parity;
   logic [3:0]           nibble;

   // message width register
   always_ff @(posedge clock) begin
      if (reset) begin
         msg_bits_ff <= nepc_pkg::MESSAGE_BITS_RESET;
      end else if (csr_write_enable) begin
         msg_bits_ff <= csr_write_data;
      end
   end

   // low-bit mask, width saturated to the stored word size
   always_comb begin
      if (msg_bits_ff > nepc_pkg::MSG_BITS_W'(W)) begin
         bits_used = nepc_pkg::MSG_BITS_W'(W);
      end else begin
         bits_used = msg_bits_ff;
      end
      for (int i = 0; i < W; i++) begin
         use_mask[i] = (nepc_pkg::MSG_BITS_W'(i) < bits_used);
      end
   end

   // load decode
   assign col_we    = cmd.accept && (req_operation == nepc_pkg::OP_LOAD_COLUMN) &&
                      (int'(req_slot_index) < COLUMNS);
   assign col_waddr = BANK_AW'(req_slot_index >> 2);
   assign chunk_we  = cmd.accept && (req_operation == nepc_pkg::OP_LOAD_CHUNK) &&
                      (int'(req_slot_index) < CHUNK_DEPTH);
   assign chunk_waddr = CHUNK_AW'(req_slot_index);

   // read addresses from the group counter
   assign col_raddr   = group_ff[BANK_AW-1:0];
   assign group_shift = group_ff >> 4;
   assign chunk_raddr = CHUNK_AW'(group_shift);

   // one bank per column position within a group
   for (genvar j = 0; j < 4; j++) begin : g_bank
      logic [W-1:0] mem [BANK_DEPTH];

      always_ff @(posedge clock) begin
         if (col_we && (req_slot_index[1:0] == 2'(j))) begin
            mem[col_waddr] <= req_data_word[W-1:0];
         end
         if (cmd.issue) begin
            col_rd_ff[j] <= mem[col_raddr];
         end
      end
   end

   // received word store
   always_ff @(posedge clock) begin
      if (chunk_we) begin
         chunk_mem[chunk_waddr] <= req_data_word;
      end
      if (cmd.issue) begin
         chunk_rd_ff <= chunk_mem[chunk_raddr];
         sub_ff      <= group_ff[3:0];
      end
   end

   // end of the group range, clipped at the stored columns
   always_comb begin
      range_end = GROUP_W'(req_first_group) + GROUP_W'(req_group_count);
      if (range_end > GROUP_W'(GROUP_LIMIT)) begin
         end_in = GROUP_W'(GROUP_LIMIT);
      end else begin
         end_in = range_end;
      end
   end

   // group walk
   always_comb begin
      group_in = group_ff;
      if (cmd.accept) begin
         group_in = GROUP_W'(req_first_group);
      end else if (cmd.issue) begin
         group_in = group_ff + GROUP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_ff <= '0;
         end_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         group_ff <= group_in;
         pend_ff  <= cmd.issue;
         if (cmd.accept) begin
            end_ff <= end_in;
         end
      end
   end

   assign status.more    = (group_ff < end_ff);
   assign status.pending = pend_ff;

   // nibble of the group read last cycle, first column in the msb
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         parity[3 - j] = ^(cand_ff & col_rd_ff[j]);
      end
      chunk_aligned = chunk_rd_ff << {sub_ff, 2'b00};
      nibble        = parity ^ chunk_aligned[63:60];
   end

   // candidate and verdict
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cand_ff  <= req_data_word[W-1:0] & use_mask;
         check_ff <= (req_operation == nepc_pkg::OP_CHECK);
         ok_ff    <= 1'b1;
      end else if (pend_ff && nepc_pkg::nibble_bad(nibble)) begin
         ok_ff <= 1'b0;
      end
   end

   assign candidate_valid = ok_ff && check_ff;
   assign was_check       = check_ff;

endmodule

>>> rtl/nibble_error_pattern_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nibble_error_pattern_checker
// Checks a candidate message against stored generator columns and a
// received word, rejecting it on any forbidden four-bit error pattern.
// ---------------------------------------------------------------------------
// Usage
//   A transaction is taken on a rising edge with start high and busy low.
//   Operation 0 writes a generator column, 1 writes a 64-bit chunk of the
//   received word, 2 checks a candidate over a range of four-column groups.
//   Every transaction gives one result on rsp_* for exactly one cycle,
//   marked by rsp_strobe; the receiver cannot stall, so none is held.
// Sequencing
//   Loads and unused codes: strobe in the cycle after acceptance, busy only
//   while the strobe is shown. Checks: the column banks are read one group per
//   cycle over the range (clipped to the stored columns, 64 groups by default);
//   the strobe comes with the registered verdict of the last group. Busy stays
//   high from acceptance until the strobe ends, so no new transaction is taken.
// Configuration
//   csr_write_data sets the number of message bits in use; write it only
//   while busy is low.
// Reset
//   Synchronous, active high: returns to idle and sets 64 message bits.
//   Column and received word stores are not cleared and must be loaded.
// ---------------------------------------------------------------------------
module nibble_error_pattern_checker #(
   parameter int COLUMNS          = nepc_pkg::COLUMNS_DEFAULT,
   parameter int MAX_MESSAGE_BITS = nepc_pkg::MAX_MESSAGE_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [nepc_pkg::OP_W-1:0]         req_operation,
   input  logic [nepc_pkg::SLOT_W-1:0]       req_slot_index,
   input  logic [nepc_pkg::DATA_W-1:0]       req_data_word,
   input  logic [nepc_pkg::FIRST_W-1:0]      req_first_group,
   input  logic [nepc_pkg::COUNT_W-1:0]      req_group_count,
   output logic                              rsp_strobe,
   output logic                              rsp_candidate_valid,
   output logic                              rsp_was_check,
   input  logic                              csr_write_enable,
   input  logic [nepc_pkg::MSG_BITS_W-1:0]   csr_write_data
);

   nepc_pkg::dp_cmd_type    cmd;
   nepc_pkg::dp_status_type status;

   // sequencer
   nepc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .busy          (busy),
      .rsp_strobe    (rsp_strobe),
      .cmd           (cmd),
      .status        (status)
   );

   // storage and check logic
   nepc_datapath #(
      .COLUMNS          (COLUMNS),
      .MAX_MESSAGE_BITS (MAX_MESSAGE_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_operation    (req_operation),
      .req_slot_index   (req_slot_index),
      .req_data_word    (req_data_word),
      .req_first_group  (req_first_group),
      .req_group_count  (req_group_count),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .candidate_valid  (rsp_candidate_valid),
      .was_check        (rsp_was_check)
   );

`ifndef SYNTHESIS
   // a result is shown for a single cycle only
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held longer than one cycle");

   // a load or unused code is answered in the next cycle
   a_load_ack: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_operation != nepc_pkg::OP_CHECK)) |=>
         (rsp_strobe && !rsp_was_check))
      else $error("load transaction not acknowledged in the next cycle");

   // a load acknowledge never claims a valid candidate
   a_load_not_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_was_check) |-> !rsp_candidate_valid)
      else $error("candidate_valid set on a load acknowledge");

   // no group read in flight while idle
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      !busy |-> (!status.pending && !cmd.issue))
      else $error("group read active while idle");
`endif

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the nibble error pattern checker. Fills the
// column store, plants received words around chosen candidates, and checks
// every acknowledge and verdict against an in-bench model of the block,
// under sender gaps, drain pauses and message width changes.
// ---------------------------------------------------------------------------
module tb_top;

   localparam int COLUMNS     = nepc_pkg::COLUMNS_DEFAULT;
   localparam int MAX_MSG     = nepc_pkg::MAX_MESSAGE_BITS_DEFAULT;
   localparam int CHUNK_DEPTH = (COLUMNS + 63) / 64;
   localparam int GROUP_LIMIT = COLUMNS / 4;
   localparam logic [nepc_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

   // one result as the block reports it
   typedef struct packed {
      logic candidate_valid;
      logic was_check;
   } verdict_type;

   logic                            clock;
   logic                            reset;
   logic                            start;
   logic                            busy;
   logic [nepc_pkg::OP_W-1:0]       req_operation;
   logic [nepc_pkg::SLOT_W-1:0]     req_slot_index;
   logic [nepc_pkg::DATA_W-1:0]     req_data_word;
   logic [nepc_pkg::FIRST_W-1:0]    req_first_group;
   logic [nepc_pkg::COUNT_W-1:0]    req_group_count;
   logic                            rsp_strobe;
   logic                            rsp_candidate_valid;
   logic                            rsp_was_check;
   logic                            csr_write_enable;
   logic [nepc_pkg::MSG_BITS_W-1:0] csr_write_data;

   // shadow copy of the block state
   logic [nepc_pkg::DATA_W-1:0]     column_store [COLUMNS];
   logic [nepc_pkg::DATA_W-1:0]     received_store [CHUNK_DEPTH];
   logic [nepc_pkg::MSG_BITS_W-1:0] message_bits;

   verdict_type pending_verdicts [$];
   int          error_count;
   int          send_idle_pct;
   int          items_sent;
   int          checks_accepted;
   int          checks_rejected;
   int          loads_acked;
   int          width_writes;

   nibble_error_pattern_checker #(
      .COLUMNS          (COLUMNS),
      .MAX_MESSAGE_BITS (MAX_MSG)
   ) u_top (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_operation       (req_operation),
      .req_slot_index      (req_slot_index),
      .req_data_word       (req_data_word),
      .req_first_group     (req_first_group),
      .req_group_count     (req_group_count),
      .rsp_strobe          (rsp_strobe),
      .rsp_candidate_valid (rsp_candidate_valid),
      .rsp_was_check       (rsp_was_check),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   initial begin
      #4000000;
      $display("simulation failed");
      $finish;
   end

   function automatic logic [63:0] rand_word();
      return {$urandom(), $urandom()};
   endfunction

   // low bits of candidate and columns that take part in the products
   function automatic logic [63:0] width_mask();
      int bits;
      bits = (int'(message_bits) > MAX_MSG) ? MAX_MSG : int'(message_bits);
      if (bits >= 64) return '1;
      return (64'd1 << bits) - 64'd1;
   endfunction

   // four inner products of the candidate with the columns of group g, msb first
   function automatic logic [3:0] coded_nibble(logic [63:0] cand, int g);
      logic [63:0] m;
      logic [3:0]  nib;
      m   = width_mask();
      nib = '0;
      for (int j = 0; j < 4; j++)
         nib = {nib[2:0], ^(cand & column_store[4 * g + j] & m)};
      return nib;
   endfunction

   function automatic logic is_forbidden(logic [3:0] nib);
      return (nib == nepc_pkg::NIB_BAD_LOW) || (nib == nepc_pkg::NIB_BAD_MID) ||
             (nib > nepc_pkg::NIB_TOP_GOOD);
   endfunction

   // verdict for a candidate over a group range, clipped to the stored columns
   function automatic logic candidate_verdict(logic [63:0] cand, logic [5:0] first,
                                              logic [6:0] count);
      logic [3:0] nib;
      logic       ok;
      ok = 1'b1;
      for (int g = int'(first); g < int'(first) + int'(count) && g < GROUP_LIMIT; g++) begin
         nib = coded_nibble(cand, g) ^ received_store[g / 16][63 - 4 * (g % 16) -: 4];
         if (is_forbidden(nib)) ok = 1'b0;
      end
      return ok;
   endfunction

   // mostly short ranges, some up to full, a few past the 64-group limit
   function automatic logic [6:0] random_group_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 7'($urandom_range(0, 16));
      if (r < 92) return 7'($urandom_range(0, 64));
      return 7'($urandom_range(65, 127));
   endfunction

   // send one transaction and record what it should answer
   task automatic send_item(input logic [nepc_pkg::OP_W-1:0] op,
                            input logic [nepc_pkg::SLOT_W-1:0] slot,
                            input logic [nepc_pkg::DATA_W-1:0] data,
                            input logic [nepc_pkg::FIRST_W-1:0] first,
                            input logic [nepc_pkg::COUNT_W-1:0] count);
      verdict_type want;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start           <= 1'b1;
      req_operation   <= op;
      req_slot_index  <= slot;
      req_data_word   <= data;
      req_first_group <= first;
      req_group_count <= count;
      @(posedge clock);
      while (busy) @(posedge clock);
      want = '0;
      case (op)
         nepc_pkg::OP_LOAD_COLUMN: begin
            if (int'(slot) < COLUMNS) column_store[slot] = data;
         end
         nepc_pkg::OP_LOAD_CHUNK: begin
            if (int'(slot) < CHUNK_DEPTH) received_store[slot] = data;
         end
         nepc_pkg::OP_CHECK: begin
            want.candidate_valid = candidate_verdict(data, first, count);
            want.was_check       = 1'b1;
         end
         default: begin
         end
      endcase
      pending_verdicts.push_back(want);
      items_sent++;
   endtask

   // hold off until every result is back and the block is idle
   task automatic wait_for_results();
      @(negedge clock);
      start <= 1'b0;
      @(posedge clock);
      while (pending_verdicts.size() != 0 || busy) @(posedge clock);
   endtask

   task automatic write_message_bits(input logic [nepc_pkg::MSG_BITS_W-1:0] value);
      wait_for_results();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      message_bits = value;
      width_writes++;
   endtask

   // load a received word equal to the codeword of cand plus allowed error
   // patterns; bad_group < 0 keeps every group allowed
   task automatic plant_received(input logic [63:0] cand, input int bad_group);
      logic [63:0] chunk;
      logic [3:0]  err;
      int          g;
      for (int i = 0; i < CHUNK_DEPTH; i++) begin
         chunk = '0;
         for (int k = 0; k < 16; k++) begin
            g   = 16 * i + k;
            err = 4'($urandom_range(0, 15));
            while (is_forbidden(err) != (g == bad_group)) err = 4'($urandom_range(0, 15));
            chunk[63 - 4 * k -: 4] = coded_nibble(cand, g) ^ err;
         end
         send_item(nepc_pkg::OP_LOAD_CHUNK, nepc_pkg::SLOT_W'(i), chunk, 6'($urandom),
                   7'($urandom));
      end
   endtask

   // result checker
   always @(posedge clock) begin : check_results
      verdict_type want;
      if (!reset && rsp_strobe !== 1'b0) begin
         if (pending_verdicts.size() == 0) begin
            error_count++;
            $error("rsp_strobe with no transaction pending");
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_candidate_valid !== want.candidate_valid) begin
               error_count++;
               $error("candidate_valid expected %0b actual %0b",
                      want.candidate_valid, rsp_candidate_valid);
            end
            if (rsp_was_check !== want.was_check) begin
               error_count++;
               $error("was_check expected %0b actual %0b", want.was_check, rsp_was_check);
            end
            if (!want.was_check) loads_acked++;
            else if (want.candidate_valid) checks_accepted++;
            else checks_rejected++;
         end
      end
   end

   // unused code and loads that land outside the received word
   task automatic test_ignored_items();
      send_item(OP_UNUSED, '1, '1, '1, '1);
      send_item(nepc_pkg::OP_LOAD_CHUNK, nepc_pkg::SLOT_W'(CHUNK_DEPTH), rand_word(),
                '0, '0);
      send_item(nepc_pkg::OP_LOAD_CHUNK, '1, '1, '0, '0);
   endtask

   // every column and every received chunk gets a defined value
   task automatic test_matrix_fill();
      send_item(nepc_pkg::OP_LOAD_COLUMN, 8'd0, '1, '0, '0);
      send_item(nepc_pkg::OP_LOAD_COLUMN, 8'd1, '0, '0, '0);
      for (int c = 2; c < COLUMNS; c++)
         send_item(nepc_pkg::OP_LOAD_COLUMN, nepc_pkg::SLOT_W'(c), rand_word(),
                   6'($urandom), 7'($urandom));
      for (int i = 0; i < CHUNK_DEPTH; i++)
         send_item(nepc_pkg::OP_LOAD_CHUNK, nepc_pkg::SLOT_W'(i), rand_word(), '0, '0);
   endtask

   // range edges, clipping and planted accept / reject cases
   task automatic test_directed_checks();
      logic [63:0] cand;
      cand = rand_word();
      send_item(nepc_pkg::OP_CHECK, '0, rand_word(), 6'd0, 7'd0);
      send_item(nepc_pkg::OP_CHECK, '1, '0, 6'd0, 7'd64);
      send_item(nepc_pkg::OP_CHECK, '0, '1, 6'd63, 7'd127);
      send_item(nepc_pkg::OP_CHECK, '0, '1, 6'd63, 7'd1);
      plant_received(cand, -1);
      send_item(nepc_pkg::OP_CHECK, '0, cand, 6'd0, 7'd64);
      send_item(nepc_pkg::OP_CHECK, '0, cand, 6'd0, 7'd127);
      send_item(nepc_pkg::OP_CHECK, '0, cand ^ 64'h1, 6'd0, 7'd64);
      plant_received(cand, GROUP_LIMIT - 1);
      send_item(nepc_pkg::OP_CHECK, '0, cand, 6'd0, 7'd64);
      send_item(nepc_pkg::OP_CHECK, '0, cand, 6'd0, 7'd63);
      send_item(nepc_pkg::OP_CHECK, '0, cand, 6'd63, 7'd1);
   endtask

   // zero width, saturated width, one bit, back to the full word
   task automatic test_message_width();
      write_message_bits(7'd0);
      plant_received(rand_word(), -1);
      send_item(nepc_pkg::OP_CHECK, '0, rand_word(), 6'd0, 7'd64);
      write_message_bits(7'd127);
      send_item(nepc_pkg::OP_CHECK, '0, rand_word(), 6'd0, 7'd64);
      write_message_bits(7'd1);
      send_item(nepc_pkg::OP_CHECK, '0, rand_word(), 6'd0, 7'd64);
      write_message_bits(nepc_pkg::MESSAGE_BITS_RESET);
   endtask

   // planted words, checks near the candidate, loads, unused codes, width writes
   task automatic test_random_traffic(input int n_items, input int idle_pct);
      logic [63:0] cand;
      int          target;
      int          r;
      send_idle_pct = idle_pct;
      target = items_sent + n_items;
      while (items_sent < target) begin
         r = $urandom_range(0, 29);
         if (r < 3) begin
            case ($urandom_range(0, 5))
               0: write_message_bits(7'd0);
               1: write_message_bits(7'd1);
               2: write_message_bits(7'd64);
               3: write_message_bits(7'd127);
               default: write_message_bits(7'($urandom_range(0, 127)));
            endcase
         end else if (r < 5) begin
            wait_for_results();
         end
         cand = rand_word();
         plant_received(cand, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : -1);
         repeat ($urandom_range(2, 8)) begin
            r = $urandom_range(0, 99);
            if (r < 55)
               send_item(nepc_pkg::OP_CHECK, 8'($urandom), cand, 6'($urandom),
                         random_group_count());
            else if (r < 70)
               send_item(nepc_pkg::OP_CHECK, 8'($urandom),
                         cand ^ (64'd1 << $urandom_range(0, 63)),
                         6'($urandom), random_group_count());
            else if (r < 80)
               send_item(nepc_pkg::OP_CHECK, 8'($urandom), rand_word(), 6'($urandom),
                         random_group_count());
            else if (r < 88)
               send_item(nepc_pkg::OP_LOAD_COLUMN, 8'($urandom), rand_word(),
                         6'($urandom), 7'($urandom));
            else if (r < 94)
               send_item(nepc_pkg::OP_LOAD_CHUNK, 8'($urandom_range(CHUNK_DEPTH, 255)),
                         rand_word(), 6'($urandom), 7'($urandom));
            else
               send_item(OP_UNUSED, 8'($urandom), rand_word(), 6'($urandom), 7'($urandom));
         end
      end
   endtask

   // stimulus sequence
   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      req_operation    = '0;
      req_slot_index   = '0;
      req_data_word    = '0;
      req_first_group  = '0;
      req_group_count  = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      message_bits     = nepc_pkg::MESSAGE_BITS_RESET;
      error_count      = 0;
      send_idle_pct    = 0;
      items_sent       = 0;
      checks_accepted  = 0;
      checks_rejected  = 0;
      loads_acked      = 0;
      width_writes     = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_ignored_items();
      test_matrix_fill();
      test_directed_checks();
      test_message_width();
      test_random_traffic(600, 21);
      test_random_traffic(600, 62);
      test_random_traffic(420, 0);

      // drain and watch for stray strobes
      wait_for_results();
      repeat (80) @(posedge clock);
      $display("%0d transactions: %0d loads or ignored, %0d checks accepted, %0d rejected",
               items_sent, loads_acked, checks_accepted, checks_rejected);
      $display("%0d message width writes, sender gaps of 21, 62 and 0 percent", width_writes);
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

>>> filelist.f
rtl/nepc_pkg.sv
rtl/nepc_ctrl.sv
rtl/nepc_datapath.sv
rtl/nibble_error_pattern_checker.sv
verif/tb_top.sv
